>>> hdl/wfps_pkg.sv
// Shared types and constants for the wall-following PID steering block.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package wfps_pkg;

    // Largest scan the sector logic is sized for. The split computation
    // below is exact for lengths up to 2047.
    localparam int MAX_SCAN_LENGTH = 1024;

    localparam int LEN_W   = 11;
    localparam int IDX_W   = 10;
    localparam int RANGE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DER_W   = 18;
    localparam int INTEG_W = 24;
    localparam int TICKS_W = 8;
    localparam int LIN_W   = 11;
    localparam int ANG_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SCAN_LENGTH);
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3);

    // len/3 is computed as (len * 683) >> 11.
    localparam logic [LEN_W-1:0] SPLIT_RECIP = LEN_W'(683);
    localparam int SPLIT_SHIFT = 11;

    localparam logic signed [LIN_W-1:0] LIN_AVOID = -11'sd50;
    localparam logic signed [LIN_W-1:0] LIN_DRIVE = 11'sd500;
    localparam logic signed [ANG_W-1:0] ANG_AVOID = 16'sd1000;
    localparam logic signed [ANG_W-1:0] ANG_ZERO  = 16'sd0;
    localparam logic signed [ANG_W-1:0] ANG_MAX   = 16'sh7FFF;
    localparam logic signed [ANG_W-1:0] ANG_MIN   = -16'sh8000;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 24'sh7FFFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = -24'sh800000;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_LENGTH = 3'd0,
        CFG_THRESHOLD   = 3'd1,
        CFG_TARGET      = 3'd2,
        CFG_KP          = 3'd3,
        CFG_KI_DT       = 3'd4,
        CFG_KD_OVER_DT  = 3'd5,
        CFG_LOST_LIMIT  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_AVOID    = 2'd0,
        KIND_STRAIGHT = 2'd1,
        KIND_PID      = 2'd2
    } kind_t;

    typedef struct packed {
        logic [RANGE_W-1:0] right;
        logic [RANGE_W-1:0] front;
        logic [RANGE_W-1:0] left;
    } sectors_t;

    // One control tick on its way from the tracking stage to the multipliers.
    typedef struct packed {
        logic                       valid;
        kind_t                      kind;
        logic                       lost;
        logic signed [ERR_W-1:0]    err;
        logic signed [INTEG_W-1:0]  integ;
        logic signed [DER_W-1:0]    der;
    } op_t;

endpackage

`default_nettype wire

>>> hdl/wall_follow_pid_steering_top.sv
// Top level of the wall-following PID steering block: input register,
// configuration registers and the sector, tracking and PID stages.
// Depends on wfps_pkg, wfps_sector, wfps_track and wfps_pid_mac.
//
// Usage:
//   The s_ channel carries one item per transfer. s_tuser[0] selects a range
//   sample (0) or a control tick (1); s_tdata holds the sample index and the
//   range. Samples update the sector minima and give no result. Each tick
//   gives exactly one result on the m_ channel: linear and angular velocity
//   and the lost flag.
//   Throughput is one item per cycle while no result is stalled. A sample
//   passes the input register and then updates the sector minima; a
//   tick's result reaches m_tvalid through the input register, tracking
//   stage, multiplier stage and result register. The three PID products are
//   formed in parallel in one stage and summed in the next.
//   When m_tready is low with a result waiting, the tick stages hold and
//   s_tready drops only once a tick sits in the input register; samples
//   keep flowing past a stalled result.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while
//   the block is idle. Reset (aresetn low, synchronous) restores register
//   defaults, sets all sector distances to the maximum range and clears
//   the lost counter, the lost flag and the PID state.
`default_nettype none

module wall_follow_pid_steering_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [9:0] sample_index, [25:10] range_mm, [31:26] zero
    input  wire logic [wfps_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] command
    input  wire logic [0:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [10:0] linear_velocity, [26:11] angular_velocity, [27] lost_state,
    // [31:28] zero
    output logic [wfps_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [wfps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wfps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import wfps_pkg::*;

    logic [LEN_W-1:0]           scan_length_reg;
    logic [RANGE_W-1:0]         threshold_reg;
    logic [RANGE_W-1:0]         target_reg;
    logic signed [GAIN_W-1:0]   kp_reg;
    logic signed [GAIN_W-1:0]   ki_reg;
    logic signed [GAIN_W-1:0]   kd_reg;
    logic [TICKS_W-1:0]         lost_limit_reg;

    logic                       in_valid_reg;
    cmd_t                       in_cmd_reg;
    logic [IDX_W-1:0]           in_idx_reg;
    logic [RANGE_W-1:0]         in_range_reg;

    logic                       adv;
    logic                       in_go;
    logic                       sample_go;
    logic                       tick_go;
    sectors_t                   sectors;
    op_t                        op;
    logic signed [LIN_W-1:0]    linear_velocity;
    logic signed [ANG_W-1:0]    angular_velocity;
    logic                       lost_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_length_reg <= LEN_W'(720);
            threshold_reg   <= RANGE_W'(500);
            target_reg      <= RANGE_W'(500);
            kp_reg          <= GAIN_W'(256);
            ki_reg          <= '0;
            kd_reg          <= '0;
            lost_limit_reg  <= TICKS_W'(75);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SCAN_LENGTH: scan_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_wdata;
                CFG_TARGET:      target_reg      <= cfg_wdata;
                CFG_KP:          kp_reg          <= cfg_wdata;
                CFG_KI_DT:       ki_reg          <= cfg_wdata;
                CFG_KD_OVER_DT:  kd_reg          <= cfg_wdata;
                CFG_LOST_LIMIT:  lost_limit_reg  <= cfg_wdata[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A sample always leaves the input register; a tick waits for the
    // tick path to move.
    assign sample_go = in_valid_reg && (in_cmd_reg == CMD_SAMPLE);
    assign tick_go   = in_valid_reg && (in_cmd_reg == CMD_TICK) && adv;
    assign in_go     = sample_go || tick_go;
    assign s_tready  = !in_valid_reg || in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= cmd_t'(s_tuser[0]);
            in_idx_reg   <= s_tdata[IDX_W-1:0];
            in_range_reg <= s_tdata[IDX_W +: RANGE_W];
        end
    end

    wfps_sector u_sector (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_go    (sample_go),
        .sample_index (in_idx_reg),
        .range_mm     (in_range_reg),
        .scan_length  (scan_length_reg),
        .sectors      (sectors)
    );

    wfps_track u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .tick_go      (tick_go),
        .sectors      (sectors),
        .threshold_mm (threshold_reg),
        .target_mm    (target_reg),
        .lost_limit   (lost_limit_reg),
        .op           (op)
    );

    wfps_pid_mac u_pid_mac (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op               (op),
        .kp               (kp_reg),
        .ki_dt            (ki_reg),
        .kd_over_dt       (kd_reg),
        .m_tready         (m_tready),
        .adv              (adv),
        .m_tvalid         (m_tvalid),
        .linear_velocity  (linear_velocity),
        .angular_velocity (angular_velocity),
        .lost_state       (lost_state)
    );

    assign m_tdata = {4'b0000, lost_state, angular_velocity, linear_velocity};

endmodule

`default_nettype wire

>>> hdl/wfps_sector.sv
// Running per-sector minima over one scan and the committed sector distances.
// Depends on wfps_pkg.
`default_nettype none

module wfps_sector (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           sample_go,
    input  wire logic [wfps_pkg::IDX_W-1:0]     sample_index,
    input  wire logic [wfps_pkg::RANGE_W-1:0]   range_mm,
    input  wire logic [wfps_pkg::LEN_W-1:0]     scan_length,
    output wfps_pkg::sectors_t                  sectors
);
    import wfps_pkg::*;

    logic [RANGE_W-1:0]           wm_reg [3];
    logic [RANGE_W-1:0]           wm_next [3];
    logic [RANGE_W-1:0]           sd_reg [3];
    logic [RANGE_W-1:0]           sd_next [3];
    logic [LEN_W-1:0]             len_eff;
    logic [2*LEN_W-1:0]           split_prod;
    logic [LEN_W-1:0]             split;
    logic [LEN_W-1:0]             idx_ext;
    logic [1:0]                   sel;
    logic                         in_scan;
    logic                         last;

    always_comb begin
        if (scan_length < MIN_LEN) begin
            len_eff = MIN_LEN;
        end else if (scan_length > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = scan_length;
        end
    end

    assign split_prod = len_eff * SPLIT_RECIP;
    assign split      = split_prod[SPLIT_SHIFT +: LEN_W];
    assign idx_ext    = LEN_W'(sample_index);
    assign in_scan    = idx_ext < len_eff;
    assign last       = idx_ext == (len_eff - LEN_W'(1));

    always_comb begin
        if (idx_ext < split) begin
            sel = 2'd0;
        end else if (idx_ext < {split[LEN_W-2:0], 1'b0}) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wm_next[i] = wm_reg[i];
            sd_next[i] = sd_reg[i];
        end
        if (sample_go && in_scan) begin
            if (range_mm < wm_reg[sel]) begin
                wm_next[sel] = range_mm;
            end
            // The closing sample commits the minima including itself.
            if (last) begin
                for (int i = 0; i < 3; i++) begin
                    sd_next[i] = wm_next[i];
                    wm_next[i] = '1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                wm_reg[i] <= '1;
                sd_reg[i] <= '1;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                wm_reg[i] <= wm_next[i];
                sd_reg[i] <= sd_next[i];
            end
        end
    end

    assign sectors.right = sd_reg[0];
    assign sectors.front = sd_reg[1];
    assign sectors.left  = sd_reg[2];

endmodule

`default_nettype wire

>>> hdl/wfps_track.sv
// Tick stage: lost tracking, command choice and the PID error state.
// Depends on wfps_pkg.
`default_nettype none

module wfps_track (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  wire logic                           tick_go,
    input  wire wfps_pkg::sectors_t             sectors,
    input  wire logic [wfps_pkg::RANGE_W-1:0]   threshold_mm,
    input  wire logic [wfps_pkg::RANGE_W-1:0]   target_mm,
    input  wire logic [wfps_pkg::TICKS_W-1:0]   lost_limit,
    output wfps_pkg::op_t                       op
);
    import wfps_pkg::*;

    logic [TICKS_W-1:0]         ticks_reg, ticks_next;
    logic                       lost_reg, lost_next;
    logic signed [ERR_W-1:0]    prev_err_reg, prev_err_next;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    op_t                        op_reg, op_next;

    logic [TICKS_W-1:0]         limit;
    logic [TICKS_W-1:0]         ticks_inc;
    logic                       all_clear;
    logic                       near;
    logic signed [ERR_W-1:0]    err;
    logic signed [DER_W-1:0]    der;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_sat;
    kind_t                      kind;

    assign limit = (lost_limit == '0) ? TICKS_W'(1) : lost_limit;
    assign all_clear = (sectors.front > threshold_mm) && (sectors.right > threshold_mm)
                    && (sectors.left > threshold_mm);
    assign near = (sectors.front < threshold_mm) || (sectors.right < threshold_mm);
    assign ticks_inc = (ticks_reg < limit) ? ticks_reg + TICKS_W'(1) : ticks_reg;

    assign err = $signed({1'b0, target_mm}) - $signed({1'b0, sectors.right});
    assign der = DER_W'(err) - DER_W'(prev_err_reg);
    assign integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err);

    always_comb begin
        if (integ_sum[INTEG_W] == integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end else if (integ_sum[INTEG_W]) begin
            integ_sat = INTEG_MIN;
        end else begin
            integ_sat = INTEG_MAX;
        end
    end

    always_comb begin
        ticks_next    = ticks_reg;
        lost_next     = lost_reg;
        prev_err_next = prev_err_reg;
        integ_next    = integ_reg;
        op_next       = op_reg;
        kind          = KIND_PID;

        if (all_clear) begin
            ticks_next = ticks_inc;
            if (ticks_inc >= limit) begin
                lost_next = 1'b1;
            end
        end else if (near) begin
            ticks_next = '0;
            lost_next  = 1'b0;
        end

        if (sectors.front < threshold_mm) begin
            kind = KIND_AVOID;
        end else if (lost_next) begin
            kind = KIND_STRAIGHT;
        end

        if (adv) begin
            op_next.valid = tick_go;
            op_next.kind  = kind;
            op_next.lost  = lost_next;
            op_next.err   = err;
            op_next.integ = integ_sat;
            op_next.der   = der;
        end

        if (!tick_go) begin
            ticks_next    = ticks_reg;
            lost_next     = lost_reg;
        end else if (kind == KIND_PID) begin
            prev_err_next = err;
            integ_next    = integ_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg    <= '0;
            lost_reg     <= 1'b0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            op_reg       <= '0;
        end else begin
            ticks_reg    <= ticks_next;
            lost_reg     <= lost_next;
            prev_err_reg <= prev_err_next;
            integ_reg    <= integ_next;
            op_reg       <= op_next;
        end
    end

    assign op = op_reg;

endmodule

`default_nettype wire

>>> hdl/wfps_pid_mac.sv
// PID products, their sum with floor scaling and saturation, and the
// result register. Depends on wfps_pkg.
`default_nettype none

module wfps_pid_mac (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire wfps_pkg::op_t                          op,
    input  wire logic signed [wfps_pkg::GAIN_W-1:0]     kp,
    input  wire logic signed [wfps_pkg::GAIN_W-1:0]     ki_dt,
    input  wire logic signed [wfps_pkg::GAIN_W-1:0]     kd_over_dt,
    input  wire logic                                   m_tready,
    output logic                                        adv,
    output logic                                        m_tvalid,
    output logic signed [wfps_pkg::LIN_W-1:0]           linear_velocity,
    output logic signed [wfps_pkg::ANG_W-1:0]           angular_velocity,
    output logic                                        lost_state
);
    import wfps_pkg::*;

    localparam int PE_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + INTEG_W;
    localparam int PD_W  = GAIN_W + DER_W;
    localparam int ACC_W = PI_W + 2;

    logic                       pv_reg;
    kind_t                      pkind_reg;
    logic                       plost_reg;
    logic signed [PE_W-1:0]     pe_reg, pe_next;
    logic signed [PI_W-1:0]     pi_reg, pi_next;
    logic signed [PD_W-1:0]     pd_reg, pd_next;

    logic                       mv_reg;
    logic signed [LIN_W-1:0]    lin_reg, lin_next;
    logic signed [ANG_W-1:0]    ang_reg, ang_next;
    logic                       lost_reg;

    logic signed [ACC_W-1:0]    acc;
    logic signed [ANG_W-1:0]    ang_pid;

    // The whole tick path moves together whenever the result slot frees up.
    assign adv = !mv_reg || m_tready;

    assign pe_next = kp * op.err;
    assign pi_next = ki_dt * op.integ;
    assign pd_next = kd_over_dt * op.der;

    assign acc = ACC_W'(pe_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);

    // Dropping the low eight bits of a two's complement value is floor(acc/256).
    always_comb begin
        if (acc[ACC_W-1:ANG_W+7] == '0 || acc[ACC_W-1:ANG_W+7] == '1) begin
            ang_pid = acc[ANG_W+7:8];
        end else if (acc[ACC_W-1]) begin
            ang_pid = ANG_MIN;
        end else begin
            ang_pid = ANG_MAX;
        end
    end

    always_comb begin
        case (pkind_reg)
            KIND_AVOID: begin
                lin_next = LIN_AVOID;
                ang_next = ANG_AVOID;
            end
            KIND_STRAIGHT: begin
                lin_next = LIN_DRIVE;
                ang_next = ANG_ZERO;
            end
            default: begin
                lin_next = LIN_DRIVE;
                ang_next = ang_pid;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else if (adv) begin
            pv_reg <= op.valid;
            mv_reg <= pv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pkind_reg <= op.kind;
            plost_reg <= op.lost;
            pe_reg    <= pe_next;
            pi_reg    <= pi_next;
            pd_reg    <= pd_next;
            lin_reg   <= lin_next;
            ang_reg   <= ang_next;
            lost_reg  <= plost_reg;
        end
    end

    assign m_tvalid         = mv_reg;
    assign linear_velocity  = lin_reg;
    assign angular_velocity = ang_reg;
    assign lost_state       = lost_reg;

endmodule

`default_nettype wire
